### design/fetc_pkg.sv
`timescale 1ns / 1ps
// shared types, register codes and fixed-point helpers for the escape-time counter
// no dependencies
package fetc_pkg;

	localparam int FETC_COUNT_BITS = 16;
	localparam int Q_W             = 32;
	localparam int QFRAC           = 26;
	localparam int PROD_W          = 2 * Q_W;
	localparam int ACC_W           = 40;
	localparam int ITER_W          = 16;
	localparam int CFG_IDX_W       = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG = 2'd3;

	// mode codes
	localparam logic MODE_JULIA      = 1'b0;
	localparam logic MODE_MANDELBROT = 1'b1;

	// escape radius squared (4) in the Q12.52 product format
	localparam logic [PROD_W:0] RADIUS_SQ = (PROD_W+1)'(4) << (2 * QFRAC);

	localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd256;

	typedef struct packed {
		logic                  mode;
		logic [ITER_W-1:0]     max_iter;
		logic signed [Q_W-1:0] c_re;
		logic signed [Q_W-1:0] c_im;
	} cfg_t;

	typedef struct packed {
		logic load;     // take a new point and pick c
		logic mul;      // register the three products
		logic step;     // write back the next z and bump the count
	} cmd_t;

	typedef struct packed {
		logic keep_going;  // below limit and still inside radius
	} status_t;

	// clamp a widened sum back to the Q6.26 range
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'({1'b0, {(Q_W-1){1'b1}}});
		lo = -hi - ACC_W'(1);
		if (v > hi)
			return {1'b0, {(Q_W-1){1'b1}}};
		else if (v < lo)
			return {1'b1, {(Q_W-1){1'b0}}};
		else
			return v[Q_W-1:0];
	endfunction

endpackage

### design/fetc_regs.sv
`timescale 1ns / 1ps
// configuration register file: mode, iteration limit, julia constant
// depends on fetc_pkg
module fetc_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [fetc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [fetc_pkg::Q_W-1:0]            wr_data,
	output fetc_pkg::cfg_t                      cfg
);
	import fetc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= MODE_JULIA;
			cfg_q.max_iter <= MAX_ITER_RESET;
			cfg_q.c_re     <= '0;
			cfg_q.c_im     <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_MODE:       cfg_q.mode     <= wr_data[0];
				REG_MAX_ITER:   cfg_q.max_iter <= wr_data[ITER_W-1:0];
				REG_CONST_REAL: cfg_q.c_re     <= $signed(wr_data);
				REG_CONST_IMAG: cfg_q.c_im     <= $signed(wr_data);
				default:        ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/fetc_ctrl.sv
`timescale 1ns / 1ps
// sequencer: load, then alternate multiply and update until escape or limit
// depends on fetc_pkg
module fetc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fetc_pkg::status_t   status,
	output fetc_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                done
);
	import fetc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_UPD  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.mul  = 1'b0;
		cmd.step = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				if (status.keep_going) begin
					cmd.step = 1'b1;
					state_d  = S_MUL;
				end else begin
					state_d  = S_DONE;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

### design/fetc_dp.sv
`timescale 1ns / 1ps
// datapath: running z, selected c, registered products, escape test, counter
// depends on fetc_pkg
module fetc_dp #(
	parameter int COUNT_BITS = fetc_pkg::FETC_COUNT_BITS
) (
	input  logic                                  clk,
	input  fetc_pkg::cmd_t                        cmd,
	input  fetc_pkg::cfg_t                        cfg,
	input  logic signed [fetc_pkg::Q_W-1:0]       point_real,
	input  logic signed [fetc_pkg::Q_W-1:0]       point_imag,
	output fetc_pkg::status_t                     status,
	output logic [fetc_pkg::ITER_W-1:0]           iterations
);
	import fetc_pkg::*;

	localparam int CMP_W = ((COUNT_BITS > ITER_W) ? COUNT_BITS : ITER_W) + 1;

	logic signed [Q_W-1:0]    x_q, y_q, ar_q, ai_q;
	logic signed [PROD_W-1:0] xx_q, yy_q, xy_q;
	logic [COUNT_BITS-1:0]    count_q;

	logic [PROD_W:0]          mag_sq;
	logic                     in_radius;
	logic                     below_limit;
	logic [CMP_W-1:0]         count_ext;
	logic signed [PROD_W-1:0] diff;
	logic signed [PROD_W-1:0] re_sh;
	logic signed [PROD_W-1:0] im_sh;
	logic signed [ACC_W-1:0]  re_sum;
	logic signed [ACC_W-1:0]  im_sum;

	// squares are never negative, so the sum is taken unsigned
	assign mag_sq    = {1'b0, xx_q} + {1'b0, yy_q};
	assign in_radius = (mag_sq < RADIUS_SQ);

	// limit is min(max_iter, all ones of the counter)
	assign count_ext   = CMP_W'(count_q);
	assign below_limit = (count_ext < CMP_W'(cfg.max_iter)) && (count_q != '1);

	assign status.keep_going = below_limit && in_radius;

	// floor back to Q6.26, doubling of x*y folded into the shift
	assign diff   = xx_q - yy_q;
	assign re_sh  = diff >>> QFRAC;
	assign im_sh  = xy_q >>> (QFRAC - 1);
	assign re_sum = $signed(re_sh[ACC_W-1:0]) + ACC_W'(ar_q);
	assign im_sum = $signed(im_sh[ACC_W-1:0]) + ACC_W'(ai_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= point_real;
			y_q     <= point_imag;
			count_q <= '0;
			if (cfg.mode == MODE_MANDELBROT) begin
				ar_q <= point_real;
				ai_q <= point_imag;
			end else begin
				ar_q <= cfg.c_re;
				ai_q <= cfg.c_im;
			end
		end else if (cmd.step) begin
			x_q     <= sat_q(re_sum);
			y_q     <= sat_q(im_sum);
			count_q <= count_q + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			xx_q <= PROD_W'(x_q) * PROD_W'(x_q);
			yy_q <= PROD_W'(y_q) * PROD_W'(y_q);
			xy_q <= PROD_W'(x_q) * PROD_W'(y_q);
		end
	end

	assign iterations = count_ext[ITER_W-1:0];

endmodule

### design/fractal_escape_time_counter.sv
`timescale 1ns / 1ps
// escape-time counter for mandelbrot and julia sets, signed Q6.26 fixed point
// top level: config registers, sequencer and datapath; depends on fetc_pkg
//
// usage
//   request channel: drive point_real / point_imag and raise start; the request
//     is taken on a rising edge with start high and busy low
//   result channel: done is high for exactly one cycle with iterations valid;
//     the receiver cannot stall, so it must take the value in that cycle
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; ready is
//     always high; write only while busy is low
//     index 0 mode (0 julia, 1 mandelbrot), 1 max_iter, 2 const_real, 3 const_imag
//   sequencing: each iteration has a multiply state for the three 32x32 products
//     and an update state for escape test, add, saturate and write-back
//   requests: one at a time; the next request can be taken in the cycle after
//     done
//   reset: asynchronous, clears the sequencer to idle and the registers to
//     julia mode, max_iter 256, zero constant
module fractal_escape_time_counter #(
	parameter int COUNT_BITS = fetc_pkg::FETC_COUNT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               start,
	output logic                               busy,
	input  logic signed [fetc_pkg::Q_W-1:0]    point_real,
	input  logic signed [fetc_pkg::Q_W-1:0]    point_imag,
	// result channel
	output logic                               done,
	output logic [fetc_pkg::ITER_W-1:0]        iterations,
	// config channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fetc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fetc_pkg::Q_W-1:0]           cfg_data
);
	import fetc_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;
	logic    ctrl_busy;

	// the user must change registers only while idle (the block does not enforce it), so writes need no back-pressure
	assign cfg_ready = 1'b1;

	fetc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// start is ignored while a point is in flight
	fetc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !ctrl_busy),
		.status (status),
		.cmd    (cmd),
		.busy   (ctrl_busy),
		.done   (done)
	);

	fetc_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.cfg        (cfg),
		.point_real (point_real),
		.point_imag (point_imag),
		.status     (status),
		.iterations (iterations)
	);

	assign busy = ctrl_busy;

endmodule

### design/fetc_checker.sv
`timescale 1ns / 1ps
// port-level checks on request / result sequencing of the escape-time counter
// binds to fractal_escape_time_counter; no package dependency
module fetc_port_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// an accepted request holds the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// a result only comes out while a request is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// the result strobe lasts one cycle and the block is idle after it
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe not a single cycle");

	// no result in the cycle right after a request is taken
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result too early after request");

endmodule

bind fractal_escape_time_counter fetc_port_checker u_fetc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
